// ===== rtl/core/fut_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Form tokenizer package
// Shared types, character and status codes, and the escape digit function
// used by the form-encoded body tokenizer.
// ----------------------------------------------------------------------------
package fut_pkg;

  typedef enum logic [1:0] {
    PH_KEY   = 2'd0,
    PH_VALUE = 2'd1,
    PH_DIG1  = 2'd2,
    PH_DIG2  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_ESC_SHORT = 2'd1,
    STAT_END_KEY   = 2'd2,
    STAT_TOO_MANY  = 2'd3
  } status_t;

  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_PCT     = 8'h25;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_ZERO    = 8'h30;

  localparam logic [7:0] UPPER_OFS = CH_UPPER_A - 8'd10;
  localparam logic [7:0] LOWER_OFS = CH_LOWER_A - 8'd10;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        in_value;
    logic [3:0]  pair_index;
    logic        token_end;
    logic        frame_end;
    logic [14:0] byte_position;
    status_t     status;
  } result_t;

  function automatic logic [7:0] digit_value(input logic [7:0] b);
    logic [7:0] v;
    if (b < CH_UPPER_A || b[7]) begin
      v = b - CH_ZERO;
    end else if (b < CH_LOWER_A) begin
      v = b - UPPER_OFS;
    end else begin
      v = b - LOWER_OFS;
    end
    return v;
  endfunction

endpackage

// ===== rtl/core/fut_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Form tokenizer parser
// Holds the parse state and forms the result of one accepted body byte.
// ----------------------------------------------------------------------------
module fut_parser #(
  parameter int MAX_PAIRS       = 16,
  parameter int MAX_FRAME_BYTES = 32768
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  logic [7:0]      data_byte,
  input  logic            last_byte,
  output logic            res_valid,
  output fut_pkg::result_t res
);
  import fut_pkg::*;

  localparam int CW = $clog2(MAX_PAIRS + 1);
  localparam int PW = $clog2(MAX_FRAME_BYTES);
  localparam logic [CW-1:0] PAIR_SAT = CW'(MAX_PAIRS);
  localparam logic [CW-1:0] PAIR_TOP = CW'(MAX_PAIRS - 1);
  localparam logic [PW-1:0] POS_TOP  = PW'(MAX_FRAME_BYTES - 1);

  phase_t        phase_r, phase_nxt;
  logic [3:0]    first_digit_r, first_digit_nxt;
  logic [CW-1:0] pair_count_r, pair_count_nxt;
  logic [PW-1:0] position_r, position_nxt;

  logic       emit;
  logic [7:0] ob;
  logic       ob_valid;
  logic       inval;
  logic       tend;
  status_t    stat_raw;
  logic       next_pair;
  logic [7:0] dv;
  logic       sat;
  logic [CW-1:0] idx;

  assign dv  = digit_value(data_byte);
  assign sat = (pair_count_r == PAIR_SAT);
  assign idx = sat ? PAIR_TOP : pair_count_r;

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_KEY: begin
        if (data_byte == CH_EQ) phase_nxt = PH_VALUE;
      end
      PH_VALUE: begin
        if (data_byte == CH_AMP) phase_nxt = PH_KEY;
        else if (data_byte == CH_PCT) phase_nxt = PH_DIG1;
      end
      PH_DIG1: begin
        if (data_byte == CH_AMP) phase_nxt = PH_KEY;
        else phase_nxt = PH_DIG2;
      end
      PH_DIG2: begin
        if (data_byte == CH_AMP) phase_nxt = PH_KEY;
        else phase_nxt = PH_VALUE;
      end
      default: phase_nxt = PH_KEY;
    endcase
  end

  always_comb begin
    emit      = 1'b1;
    ob        = 8'd0;
    ob_valid  = 1'b0;
    inval     = 1'b0;
    tend      = 1'b0;
    stat_raw  = STAT_OK;
    next_pair = 1'b0;
    case (phase_r)
      PH_KEY: begin
        if (data_byte != CH_EQ) begin
          ob       = data_byte;
          ob_valid = 1'b1;
          if (last_byte) begin
            tend     = 1'b1;
            stat_raw = STAT_END_KEY;
          end
        end else begin
          tend = 1'b1;
        end
      end
      PH_VALUE: begin
        inval = 1'b1;
        if (data_byte == CH_AMP) begin
          tend      = 1'b1;
          next_pair = 1'b1;
          if (last_byte) stat_raw = STAT_END_KEY;
        end else if (data_byte == CH_PCT) begin
          if (last_byte) begin
            tend     = 1'b1;
            stat_raw = STAT_ESC_SHORT;
          end else begin
            emit = 1'b0;
          end
        end else begin
          ob       = data_byte;
          ob_valid = 1'b1;
          tend     = last_byte;
        end
      end
      PH_DIG1: begin
        inval = 1'b1;
        if (data_byte == CH_AMP) begin
          tend      = 1'b1;
          stat_raw  = STAT_ESC_SHORT;
          next_pair = 1'b1;
        end else if (last_byte) begin
          tend     = 1'b1;
          stat_raw = STAT_ESC_SHORT;
        end else begin
          emit = 1'b0;
        end
      end
      PH_DIG2: begin
        inval = 1'b1;
        if (data_byte == CH_AMP) begin
          tend      = 1'b1;
          stat_raw  = STAT_ESC_SHORT;
          next_pair = 1'b1;
        end else begin
          ob       = {first_digit_r, 4'd0} + dv;
          ob_valid = 1'b1;
          tend     = last_byte;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  always_comb begin
    res.out_byte      = ob;
    res.byte_valid    = ob_valid;
    res.in_value      = inval;
    res.pair_index    = 4'(idx);
    res.token_end     = tend;
    res.frame_end     = last_byte;
    res.byte_position = 15'(position_r);
    res.status        = (stat_raw == STAT_OK && sat) ? STAT_TOO_MANY : stat_raw;
    res_valid         = take && emit;
  end

  always_comb begin
    first_digit_nxt = first_digit_r;
    if (phase_r == PH_DIG1 && data_byte != CH_AMP) first_digit_nxt = dv[3:0];
    pair_count_nxt = pair_count_r;
    if (next_pair && !sat) pair_count_nxt = pair_count_r + 1'b1;
    position_nxt = position_r;
    if (position_r != POS_TOP) position_nxt = position_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_KEY;
      first_digit_r <= 4'd0;
      pair_count_r  <= '0;
      position_r    <= '0;
    end else if (take) begin
      if (last_byte) begin
        phase_r       <= PH_KEY;
        first_digit_r <= 4'd0;
        pair_count_r  <= '0;
        position_r    <= '0;
      end else begin
        phase_r       <= phase_nxt;
        first_digit_r <= first_digit_nxt;
        pair_count_r  <= pair_count_nxt;
        position_r    <= position_nxt;
      end
    end
  end

endmodule

// ===== rtl/core/form_urlencoded_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Form-encoded body tokenizer
// Splits a form-encoded body into key and value bytes with percent decoding.
//
// The input channel carries one body byte per transfer, with in_last_byte
// marking the final byte. The result channel carries at most one result per
// input byte: a raw key byte, a decoded value byte or a marker, tagged with
// its pair index, part, token end, frame end, byte position and status.
// A percent sign or first escape digit inside a value gives no result unless
// it is the final byte of the body.
// Each result is registered before it appears on the output. The
// block takes one byte per cycle as long as the receiver keeps up; the rate
// is set by the parse state registers updated on each transfer.
// When the receiver stalls, one further result is held in a skid register
// and in_stall rises on the following cycle, so nothing is lost.
// Reset returns the parser to the key phase, clears the pair count and the
// byte position and empties both output registers. After a final byte the
// parse state returns to its reset values.
// ----------------------------------------------------------------------------
module form_urlencoded_tokenizer #(
  parameter int MAX_PAIRS       = 16,
  parameter int MAX_FRAME_BYTES = 32768
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_in_value,
  output logic [3:0]  out_pair_index,
  output logic        out_token_end,
  output logic        out_frame_end,
  output logic [14:0] out_byte_position,
  output logic [1:0]  out_status
);
  import fut_pkg::*;

  logic    take;
  logic    res_valid;
  result_t res;
  logic    out_fire;

  logic    out_valid_r;
  result_t out_data_r;
  logic    skid_valid_r;
  result_t skid_data_r;

  assign in_stall = skid_valid_r;
  assign take     = in_valid && !skid_valid_r;
  assign out_fire = out_valid_r && !out_stall;

  fut_parser #(
    .MAX_PAIRS       (MAX_PAIRS),
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (!out_valid_r || out_fire) begin
      out_valid_r <= res_valid;
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) out_data_r <= skid_data_r;
    end else if (!out_valid_r || out_fire) begin
      if (res_valid) out_data_r <= res;
    end else if (res_valid) begin
      skid_data_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_data_r.out_byte;
  assign out_byte_valid    = out_data_r.byte_valid;
  assign out_in_value      = out_data_r.in_value;
  assign out_pair_index    = out_data_r.pair_index;
  assign out_token_end     = out_data_r.token_end;
  assign out_frame_end     = out_data_r.frame_end;
  assign out_byte_position = out_data_r.byte_position;
  assign out_status        = out_data_r.status;

endmodule
